/* rtl/core/threshold_priority_queue_core_macros.svh */
// Assertion macros shared by the threshold priority queue RTL.
`ifndef THRESHOLD_PRIORITY_QUEUE_CORE_MACROS_SVH
`define THRESHOLD_PRIORITY_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TPQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TPQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must never be seen.
`define TPQ_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

/* rtl/core/tpq_pkg.sv */
// Types, constants and command codes of the threshold priority queue.
package tpq_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int CMD_W    = 2;
    localparam int AGE_W    = 8;
    localparam int TAG_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_ENQ      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PRIO_ENQ = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEQ      = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REVERSE  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic REG_PRIORITY_AGE = 1'b0;

    localparam logic [AGE_W-1:0] PRIORITY_AGE_RESET = 8'd65;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT,
        CELL_LOAD_KEY,
        CELL_SORT
    } cell_op_t;

    typedef struct packed {
        logic [AGE_W-1:0] age;
        logic [TAG_W-1:0] tag;
    } entry_t;

    // Broadcast to every cell each cycle.
    typedef struct packed {
        cell_op_t         op;
        logic [AGE_W-1:0] age;
        logic [TAG_W-1:0] tag;
        logic             prio;
        logic             phase;
    } cell_ctrl_t;

endpackage

/* rtl/core/tpq_if.sv */
// Command and response stream interfaces of the threshold priority queue.
interface tpq_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [tpq_pkg::CMD_W-1:0]  command;
    logic [tpq_pkg::AGE_W-1:0]  age;
    logic [tpq_pkg::TAG_W-1:0]  person_tag;

    modport source (output valid, command, age, person_tag, input ready);
    modport sink   (input valid, command, age, person_tag, output ready);
endinterface

interface tpq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tpq_pkg::STATUS_W-1:0]  status;
    logic [tpq_pkg::AGE_W-1:0]     out_age;
    logic [tpq_pkg::TAG_W-1:0]     out_tag;
    logic [tpq_pkg::COUNT_W-1:0]   entry_count;

    modport source (output valid, status, out_age, out_tag, entry_count, input ready);
    modport sink   (input valid, status, out_age, out_tag, entry_count, output ready);
endinterface

/* rtl/core/tpq_regs.sv */
// APB register block: holds the priority age threshold.
module tpq_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpq_pkg::PADDR_W-1:0]   paddr,
    input  logic [tpq_pkg::PDATA_W-1:0]   pwdata,
    output logic [tpq_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [tpq_pkg::AGE_W-1:0]     priority_age
);
    import tpq_pkg::*;

    logic             wr_en;
    logic             reg_index;
    logic [AGE_W-1:0] prio_age_reg;
    logic [AGE_W-1:0] prio_age_next;

    assign reg_index = paddr[2];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && (reg_index == REG_PRIORITY_AGE);

    always_comb
    begin
        prio_age_next = prio_age_reg;
        if (wr_en)
        begin
            prio_age_next = pwdata[AGE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_age_reg <= PRIORITY_AGE_RESET;
        end
        else
        begin
            prio_age_reg <= prio_age_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_PRIORITY_AGE)
        begin
            prdata = {{(PDATA_W - AGE_W){1'b0}}, prio_age_reg};
        end
    end

    assign priority_age = prio_age_reg;

endmodule

/* rtl/core/tpq_cell.sv */
// One queue cell: holds an entry and a sort key, trades with its two neighbors.
module tpq_cell #(
    parameter int DEPTH = tpq_pkg::DEPTH_DEF,
    parameter int INDEX = 0
) (
    input  logic                           clk,
    input  tpq_pkg::cell_ctrl_t            ctrl,
    input  logic [$clog2(DEPTH+1)-1:0]     count,
    input  tpq_pkg::entry_t                left_entry,
    input  logic [$clog2(DEPTH)-1:0]       left_key,
    input  logic                           found_in,
    input  tpq_pkg::entry_t                right_entry,
    input  logic [$clog2(DEPTH)-1:0]       right_key,
    input  logic                           swap_in,
    output tpq_pkg::entry_t                entry,
    output logic [$clog2(DEPTH)-1:0]       key,
    output logic                           found_out,
    output logic                           swap_out
);
    import tpq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);
    // parity of the pair (INDEX-1, INDEX)
    localparam logic LEFT_PHASE = 1'((INDEX + 1) % 2);

    entry_t           entry_reg;
    entry_t           entry_next;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             valid;
    logic             hit;
    logic [CNT_W-1:0] rev_pos;

    assign valid = IDX < count;
    // first hit from the head marks the insertion slot; the tail slot always hits
    assign hit       = (valid && ctrl.prio && (entry_reg.age < ctrl.age)) || (IDX == count);
    assign found_out = found_in | hit;
    assign rev_pos   = count - IDX - CNT_W'(1);

    generate
        if (INDEX == 0)
        begin : g_head
            assign swap_out = 1'b0;
        end
        else
        begin : g_body
            assign swap_out = (ctrl.op == CELL_SORT) && (ctrl.phase == LEFT_PHASE) && valid
                              && (left_key > key_reg);
        end
    endgenerate

    always_comb
    begin
        entry_next = entry_reg;
        key_next   = key_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
            end
            CELL_INSERT:
            begin
                if (found_in)
                begin
                    entry_next = left_entry;
                end
                else if (hit)
                begin
                    entry_next.age = ctrl.age;
                    entry_next.tag = ctrl.tag;
                end
            end
            CELL_SHIFT:
            begin
                entry_next = right_entry;
            end
            CELL_LOAD_KEY:
            begin
                key_next = rev_pos[KEY_W-1:0];
            end
            CELL_SORT:
            begin
                if (swap_in)
                begin
                    entry_next = right_entry;
                    key_next   = right_key;
                end
                else if (swap_out)
                begin
                    entry_next = left_entry;
                    key_next   = left_key;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        key_reg   <= key_next;
    end

    assign entry = entry_reg;
    assign key   = key_reg;

endmodule

/* rtl/core/threshold_priority_queue_core.sv */
// Top level of the threshold priority queue: sequencer, result register, cell chain.
//
//   Channel  Kind      Direction  Carries
//   cmd      stream    in         command, age, person_tag
//   rsp      stream    out        status, out_age, out_tag, entry_count
//   apb      register  in/out     priority_age at byte address 0
//
// Enqueue and priority enqueue: all cells compare against the new age in parallel
// and shift in the same cycle; dequeue shifts every cell toward the head.
// Reverse of N >= 2 entries first loads target keys into the cells, then runs N odd-even
// exchange rounds between neighboring cells; with fewer it answers without touching the cells.
// rst_n clears the count, the sequencer and the result valid flag.
// A result waiting in the output register holds off the next command until it
// is taken; a result transfer in the same cycle frees the slot.
`include "threshold_priority_queue_core_macros.svh"

module threshold_priority_queue_core #(
    parameter int DEPTH = tpq_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tpq_cmd_if.sink                       cmd,
    tpq_rsp_if.source                     rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpq_pkg::PADDR_W-1:0]   paddr,
    input  logic [tpq_pkg::PDATA_W-1:0]   pwdata,
    output logic [tpq_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import tpq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = $clog2(DEPTH);
    localparam int EXT_W = CNT_W + COUNT_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    localparam logic S_IDLE    = 1'b0;
    localparam logic S_REVERSE = 1'b1;

    logic [AGE_W-1:0] priority_age;

    logic             state_reg;
    logic             state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] round_reg;
    logic [CNT_W-1:0] round_next;
    logic [EXT_W-1:0] count_ext;

    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [AGE_W-1:0]    out_age_reg;
    logic [AGE_W-1:0]    out_age_next;
    logic [TAG_W-1:0]    out_tag_reg;
    logic [TAG_W-1:0]    out_tag_next;
    logic [COUNT_W-1:0]  entry_count_reg;
    logic [COUNT_W-1:0]  entry_count_next;

    logic       out_free;
    logic       accept;
    logic       load_rsp;
    logic       last_round;
    cell_ctrl_t ctrl;

    entry_t           ent_w  [DEPTH+2];
    logic [KEY_W-1:0] key_w  [DEPTH+2];
    logic             found  [DEPTH+1];
    logic             swap_l [DEPTH+1];

    tpq_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .priority_age (priority_age)
    );

    assign out_free   = !rsp_valid_reg || rsp.ready;
    assign cmd.ready  = (state_reg == S_IDLE) && out_free;
    assign accept     = cmd.valid && cmd.ready;
    assign last_round = (round_reg == (count_reg - CNT_W'(1)));

    always_comb
    begin
        ctrl.op    = CELL_HOLD;
        ctrl.age   = cmd.age;
        ctrl.tag   = cmd.person_tag;
        ctrl.prio  = (cmd.command == CMD_PRIO_ENQ) && (cmd.age >= priority_age);
        ctrl.phase = round_reg[0];

        state_next   = state_reg;
        count_next   = count_reg;
        round_next   = round_reg;
        load_rsp     = 1'b0;
        status_next  = ST_DONE;
        out_age_next = '0;
        out_tag_next = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.command) inside
                        CMD_ENQ, CMD_PRIO_ENQ:
                        begin
                            load_rsp = 1'b1;
                            if (count_reg == FULL_COUNT)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ctrl.op    = CELL_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_DEQ:
                        begin
                            load_rsp = 1'b1;
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ctrl.op      = CELL_SHIFT;
                                count_next   = count_reg - CNT_W'(1);
                                out_age_next = ent_w[1].age;
                                out_tag_next = ent_w[1].tag;
                            end
                        end
                        CMD_REVERSE:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                load_rsp = 1'b1;
                            end
                            else
                            begin
                                ctrl.op    = CELL_LOAD_KEY;
                                round_next = '0;
                                state_next = S_REVERSE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_REVERSE:
            begin
                // extra rounds while the result waits are no-ops: the order is settled
                ctrl.op = CELL_SORT;
                if (!last_round)
                begin
                    round_next = round_reg + CNT_W'(1);
                end
                else if (out_free)
                begin
                    load_rsp   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign count_ext        = EXT_W'(count_next);
    assign entry_count_next = count_ext[COUNT_W-1:0];

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        if (load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            round_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            round_reg     <= round_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_rsp)
        begin
            status_reg      <= status_next;
            out_age_reg     <= out_age_next;
            out_tag_reg     <= out_tag_next;
            entry_count_reg <= entry_count_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.out_age     = out_age_reg;
    assign rsp.out_tag     = out_tag_reg;
    assign rsp.entry_count = entry_count_reg;

    // Chain ends: slot 0 feeds the head cell, slot DEPTH+1 the tail cell.
    assign ent_w[0].age      = cmd.age;
    assign ent_w[0].tag      = cmd.person_tag;
    assign key_w[0]          = '0;
    assign ent_w[DEPTH+1]    = '0;
    assign key_w[DEPTH+1]    = '0;
    assign found[0]          = 1'b0;
    assign swap_l[DEPTH]     = 1'b0;

    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            tpq_cell #(
                .DEPTH (DEPTH),
                .INDEX (i)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .count       (count_reg),
                .left_entry  (ent_w[i]),
                .left_key    (key_w[i]),
                .found_in    (found[i]),
                .right_entry (ent_w[i+2]),
                .right_key   (key_w[i+2]),
                .swap_in     (swap_l[i+1]),
                .entry       (ent_w[i+1]),
                .key         (key_w[i+1]),
                .found_out   (found[i+1]),
                .swap_out    (swap_l[i])
            );
        end
    endgenerate

    `TPQ_ASSERT_NEVER(a_head_no_left_swap, swap_l[0], "head cell requested a swap to its left")
    `TPQ_ASSERT_IMP(a_insert_has_slot, ctrl.op == CELL_INSERT, found[DEPTH], "insert found no slot")
    `TPQ_ASSERT_IMP(a_reverse_needs_two, state_reg == S_REVERSE, count_reg >= CNT_W'(2), "reverse run with fewer than two entries")
    `TPQ_ASSERT_NXT(a_deq_drops_one, accept && cmd.command == CMD_DEQ && count_reg != '0, count_reg == $past(count_reg) - CNT_W'(1), "dequeue did not drop one entry")

endmodule
